// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file smf_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK_RST(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked property that also holds during reset.
`define ASSERT_CLK(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/smf_pkg.sv =====
// Types, codes and helpers for the spiral matrix filler.
package smf_pkg;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    // Dimension math width: holds counts up to 256 plus one step.
    localparam int DIM_W     = 9;
    localparam int IDX_W     = 17;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_DAT_W-1:0] CNT_RESET     = CFG_DAT_W'(16);

    typedef enum logic [1:0] {
        OP_PLACE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_DOWN  = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_UP    = 2'd3
    } heading_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOK,
        ST_TURN,
        ST_READ,
        ST_ZERO
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] value;
        logic [3:0]  read_row;
        logic [3:0]  read_col;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  cell_row;
        logic [3:0]  cell_col;
        logic [15:0] cell_value;
        logic        cell_filled;
        logic        overflow;
    } out_item_t;

    typedef struct packed {
        logic             ok;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } step_t;

    // Neighbor of (r,c) in heading h; ok is low when it leaves the matrix.
    function automatic step_t step_toward(input logic [DIM_W-1:0] r,
                                          input logic [DIM_W-1:0] c,
                                          input heading_t         h,
                                          input logic [DIM_W-1:0] rows,
                                          input logic [DIM_W-1:0] cols);
        step_t s;
        s.ok  = 1'b1;
        s.row = r;
        s.col = c;
        case (h)
            HEAD_RIGHT: s.col = c + DIM_W'(1);
            HEAD_DOWN:  s.row = r + DIM_W'(1);
            HEAD_LEFT: begin
                if (c == '0) s.ok = 1'b0;
                else         s.col = c - DIM_W'(1);
            end
            HEAD_UP: begin
                if (r == '0) s.ok = 1'b0;
                else         s.row = r - DIM_W'(1);
            end
            default: s.ok = 1'b0;
        endcase
        if (s.row >= rows || s.col >= cols) s.ok = 1'b0;
        return s;
    endfunction

endpackage

// ===== hw/rtl/spiral_order_matrix_fill.sv =====
// Spiral matrix filler top level: control FSM, filled map and value store.
// Flow: a place goes through LOOK, and also TURN when the path turns; reads
//   go through READ, ignored opcodes through ZERO; a clear goes SWEEP, ZERO.
// One item at a time: s_ready is high only in IDLE, since the filled-map
//   memory reads are registered; clear costs a sweep of every cell.
// Reset: synchronous, active low; then a sweep of every cell zeroes
//   the filled map before the first input transfer is taken.
module spiral_order_matrix_fill #(
    parameter int MAX_ROWS = smf_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = smf_pkg::DEF_MAX_COLS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input item channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  smf_pkg::in_item_t                   s_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output smf_pkg::out_item_t                  m_data,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [smf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [smf_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import smf_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [DIM_W-1:0] ROWS_MAX  = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] COLS_MAX  = DIM_W'(MAX_COLS);
    localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);

    // Row-major cell address, stride MAX_COLS.
    function automatic logic [AW-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                input logic [DIM_W-1:0] c);
        logic [IDX_W-1:0] lin;
        lin = IDX_W'(r) * IDX_W'(MAX_COLS) + IDX_W'(c);
        return lin[AW-1:0];
    endfunction

    // Control state
    state_t                 state_reg, state_next;
    logic [RW-1:0]          pos_row_reg, pos_row_next;
    logic [CW-1:0]          pos_col_reg, pos_col_next;
    heading_t               head_reg, head_next;
    logic [AW-1:0]          clr_idx_reg, clr_idx_next;
    logic                   clr_resp_reg, clr_resp_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CFG_DAT_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [CFG_DAT_W-1:0]   col_cnt_reg, col_cnt_next;

    // Per-item payload
    logic [15:0]            val_reg, val_next;
    logic [3:0]             op_row_reg, op_row_next;
    logic [3:0]             op_col_reg, op_col_next;
    logic                   rd_ok_reg, rd_ok_next;
    out_item_t              m_data_reg, m_data_next;

    // Memories: filled map (two read ports) and value store (one read port)
    logic                   fill_mem [CELLS];
    logic [15:0]            val_mem  [CELLS];
    logic                   fill_a_reg, fill_b_reg;
    logic [15:0]            vdata_reg;
    logic                   rd_a_en, rd_b_en, rd_v_en;
    logic [AW-1:0]          addr_a, addr_b, addr_v;
    logic                   wr_en, wr_fill, wr_val_en;
    logic [AW-1:0]          wr_addr;

    // Combinational helpers
    logic [DIM_W-1:0]       eff_rows, eff_cols;
    logic [DIM_W-1:0]       pos_r9, pos_c9;
    logic [DIM_W-1:0]       rd_r9, rd_c9;
    logic                   pos_ok, out_free;
    step_t                  cur_step, turn_step;
    heading_t               turn_head;

    // Counts of zero act as one; counts above the store size saturate.
    always_comb begin
        if (row_cnt_reg == '0)                   eff_rows = DIM_W'(1);
        else if (DIM_W'(row_cnt_reg) > ROWS_MAX) eff_rows = ROWS_MAX;
        else                                     eff_rows = DIM_W'(row_cnt_reg);
        if (col_cnt_reg == '0)                   eff_cols = DIM_W'(1);
        else if (DIM_W'(col_cnt_reg) > COLS_MAX) eff_cols = COLS_MAX;
        else                                     eff_cols = DIM_W'(col_cnt_reg);
    end

    assign pos_r9    = DIM_W'(pos_row_reg);
    assign pos_c9    = DIM_W'(pos_col_reg);
    assign rd_r9     = DIM_W'(s_data.read_row);
    assign rd_c9     = DIM_W'(s_data.read_col);
    // Position can fall outside the matrix only after the counts shrink.
    assign pos_ok    = (pos_r9 < eff_rows) && (pos_c9 < eff_cols);
    assign out_free  = !m_valid_reg || m_ready;
    assign turn_head = heading_t'(head_reg + 2'd1);
    assign cur_step  = step_toward(pos_r9, pos_c9, head_reg, eff_rows, eff_cols);
    assign turn_step = step_toward(pos_r9, pos_c9, turn_head, eff_rows, eff_cols);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Next state, memory control and result formation
    always_comb begin
        state_next    = state_reg;
        pos_row_next  = pos_row_reg;
        pos_col_next  = pos_col_reg;
        head_next     = head_reg;
        clr_idx_next  = clr_idx_reg;
        clr_resp_next = clr_resp_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        row_cnt_next  = row_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        val_next      = val_reg;
        op_row_next   = op_row_reg;
        op_col_next   = op_col_reg;
        rd_ok_next    = rd_ok_reg;
        m_data_next   = m_data_reg;
        rd_a_en       = 1'b0;
        rd_b_en       = 1'b0;
        rd_v_en       = 1'b0;
        addr_a        = '0;
        addr_b        = '0;
        addr_v        = '0;
        wr_en         = 1'b0;
        wr_fill       = 1'b0;
        wr_val_en     = 1'b0;
        wr_addr       = cell_addr(pos_r9, pos_c9);

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_cnt_next = cfg_data;
                CFG_COL_COUNT: col_cnt_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_SWEEP: begin
                // one filled-map entry zeroed per cycle
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == LAST_CELL) begin
                    clr_idx_next  = '0;
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? ST_ZERO : ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.opcode)
                        OP_PLACE: begin
                            // current cell and the cell ahead, read together
                            rd_a_en    = 1'b1;
                            addr_a     = cell_addr(pos_r9, pos_c9);
                            rd_b_en    = 1'b1;
                            addr_b     = cell_addr(cur_step.row, cur_step.col);
                            val_next   = s_data.value;
                            state_next = ST_LOOK;
                        end
                        OP_READ: begin
                            op_row_next = s_data.read_row;
                            op_col_next = s_data.read_col;
                            rd_ok_next  = (rd_r9 < eff_rows) && (rd_c9 < eff_cols);
                            rd_a_en     = 1'b1;
                            addr_a      = cell_addr(rd_r9, rd_c9);
                            rd_v_en     = 1'b1;
                            addr_v      = cell_addr(rd_r9, rd_c9);
                            state_next  = ST_READ;
                        end
                        OP_CLEAR: begin
                            pos_row_next  = '0;
                            pos_col_next  = '0;
                            head_next     = HEAD_RIGHT;
                            clr_idx_next  = '0;
                            clr_resp_next = 1'b1;
                            state_next    = ST_SWEEP;
                        end
                        default: state_next = ST_ZERO;
                    endcase
                end
            end

            ST_LOOK: begin
                if (!pos_ok || fill_a_reg) begin
                    // dropped place: report position, flag overflow
                    if (out_free) begin
                        m_valid_next            = 1'b1;
                        m_data_next             = '0;
                        m_data_next.cell_row    = 4'(pos_row_reg);
                        m_data_next.cell_col    = 4'(pos_col_reg);
                        m_data_next.overflow    = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end else if (cur_step.ok && !fill_b_reg) begin
                    if (out_free) begin
                        wr_en                   = 1'b1;
                        wr_fill                 = 1'b1;
                        wr_val_en               = 1'b1;
                        pos_row_next            = RW'(cur_step.row);
                        pos_col_next            = CW'(cur_step.col);
                        m_valid_next            = 1'b1;
                        m_data_next             = '0;
                        m_data_next.cell_row    = 4'(pos_row_reg);
                        m_data_next.cell_col    = 4'(pos_col_reg);
                        m_data_next.cell_value  = val_reg;
                        m_data_next.cell_filled = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end else begin
                    // blocked ahead: turn clockwise and probe again
                    rd_b_en    = 1'b1;
                    addr_b     = cell_addr(turn_step.row, turn_step.col);
                    head_next  = turn_head;
                    state_next = ST_TURN;
                end
            end

            ST_TURN: begin
                // head_reg already holds the new heading
                if (out_free) begin
                    wr_en     = 1'b1;
                    wr_fill   = 1'b1;
                    wr_val_en = 1'b1;
                    if (cur_step.ok && !fill_b_reg) begin
                        pos_row_next = RW'(cur_step.row);
                        pos_col_next = CW'(cur_step.col);
                    end
                    m_valid_next            = 1'b1;
                    m_data_next             = '0;
                    m_data_next.cell_row    = 4'(pos_row_reg);
                    m_data_next.cell_col    = 4'(pos_col_reg);
                    m_data_next.cell_value  = val_reg;
                    m_data_next.cell_filled = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            ST_READ: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next             = '0;
                    m_data_next.cell_row    = op_row_reg;
                    m_data_next.cell_col    = op_col_reg;
                    if (rd_ok_reg && fill_a_reg) begin
                        m_data_next.cell_value  = vdata_reg;
                        m_data_next.cell_filled = 1'b1;
                    end
                    state_next              = ST_IDLE;
                end
            end

            ST_ZERO: begin
                // clear and unused opcode: all-zero result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // FSM state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_row_reg  <= '0;
            pos_col_reg  <= '0;
            head_reg     <= HEAD_RIGHT;
            clr_idx_reg  <= '0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            row_cnt_reg  <= CNT_RESET;
            col_cnt_reg  <= CNT_RESET;
        end else begin
            pos_row_reg  <= pos_row_next;
            pos_col_reg  <= pos_col_next;
            head_reg     <= head_next;
            clr_idx_reg  <= clr_idx_next;
            clr_resp_reg <= clr_resp_next;
            m_valid_reg  <= m_valid_next;
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        op_row_reg <= op_row_next;
        op_col_reg <= op_col_next;
        rd_ok_reg  <= rd_ok_next;
        m_data_reg <= m_data_next;
    end

    // Memories: registered reads hold their data until the next read
    always_ff @(posedge aclk) begin
        if (wr_en)     fill_mem[wr_addr] <= wr_fill;
        if (wr_val_en) val_mem[wr_addr]  <= val_reg;
        if (rd_a_en)   fill_a_reg        <= fill_mem[addr_a];
        if (rd_b_en)   fill_b_reg        <= fill_mem[addr_b];
        if (rd_v_en)   vdata_reg         <= val_mem[addr_v];
    end

endmodule

// ===== hw/rtl/smf_chk.sv =====
// Port-level checker for the spiral matrix filler, bound to the top level.
`include "assert_macros.svh"

module smf_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input smf_pkg::in_item_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input smf_pkg::out_item_t  m_data
);
    import smf_pkg::*;

    // held result stays put until taken
    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // a dropped place never reports a stored value
    `ASSERT_CLK_RST(a_ovf_empty, aclk, aresetn, m_valid && m_data.overflow |-> !m_data.cell_filled && m_data.cell_value == 16'd0)

    // one item at a time: busy in the cycle after a transfer
    `ASSERT_CLK_RST(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // reset starts the map sweep, so no input is taken right after it
    `ASSERT_CLK(a_sweep_after_rst, aclk, !aresetn |=> !s_ready)

endmodule

bind spiral_order_matrix_fill smf_chk u_smf_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
